FILE: rtl/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg: shared constants, types and elaboration-time tables
// WGS84 constants, CORDIC tables, stage latencies and register indexes
// for the geodetic to local ENU converter.
// ----------------------------------------------------------------------------
package gte_pkg;

	localparam int CORDIC_STEPS_DFLT  = 32;
	localparam int FRACTION_BITS_DFLT = 30;
	localparam int NEWTON_ROUNDS      = 6;
	localparam int MUL_LAT            = 3;

	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int HGT_W    = 28;
	localparam int OUT_W    = 35;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LON = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_HGT = 2'd2;

	localparam logic signed [63:0] ONE_Q62      = 64'sh4000_0000_0000_0000;
	localparam logic signed [63:0] THREE_Q61    = 64'sh6000_0000_0000_0000;
	localparam logic signed [63:0] E2_Q62       = 64'sd30872378602568466;
	localparam logic signed [63:0] ONE_MINUS_E2 = ONE_Q62 - E2_Q62;
	localparam logic signed [63:0] RE_MM        = 64'sd6378137000;
	localparam logic signed [63:0] LIMIT_MM     = 64'sd16000000000;
	localparam logic signed [63:0] HALF_MM_Q16  = 64'sd32768;
	localparam logic signed [63:0] X0_GUESS     = (ONE_Q62 / 64'sd10) * 64'sd6;

	typedef struct packed {
		logic signed [63:0] sp;
		logic signed [63:0] cp;
		logic signed [63:0] sl;
		logic signed [63:0] cl;
	} trig_t;

	function automatic logic signed [63:0] mul_c(input logic signed [63:0] a,
			input logic signed [63:0] b, input int s);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		p = p >>> s;
		return p[63:0];
	endfunction

	function automatic logic signed [63:0] div_c(input logic signed [63:0] n,
			input logic signed [63:0] d);
		logic [63:0] q, rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= $unsigned(d)) begin
				rem = rem - $unsigned(d);
				q[b] = 1'b1;
			end
		end
		return $signed(q);
	endfunction

	function automatic logic signed [63:0] pi4_q62();
		logic signed [63:0] res, sum, t, q, q2, term;
		int k;
		res = 64'sd0;
		for (int j = 0; j < 2; j++) begin
			q = (j == 0) ? 64'sd5 : 64'sd239;
			t = div_c(ONE_Q62, q);
			q2 = q * q;
			sum = 64'sd0;
			k = 0;
			while (t != 64'sd0) begin
				term = div_c(t, 64'(2 * k + 1));
				sum = k[0] ? sum - term : sum + term;
				t = div_c(t, q2);
				k++;
			end
			res = (j == 0) ? 64'sd4 * sum : res - sum;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] atan_entry(input int i, input int frac);
		logic signed [63:0] sum, term;
		int k, e;
		sum = 64'sd0;
		if (i == 0) begin
			sum = pi4_q62();
		end else begin
			k = 0;
			e = 62 - i;
			while (e >= 0) begin
				term = div_c(64'sd1 <<< e, 64'(2 * k + 1));
				sum = k[0] ? sum - term : sum + term;
				k++;
				e = 62 - i * (2 * k + 1);
			end
		end
		return sum >>> (62 - frac);
	endfunction

	function automatic logic signed [63:0] cordic_x0(input int steps, input int frac);
		logic signed [63:0] g, y, y2, t;
		g = 64'sd1 <<< 60;
		for (int i = 0; i < steps; i++) begin
			if (2 * i < 64) g = g + (g >>> (2 * i));
		end
		y = X0_GUESS;
		for (int r = 0; r < NEWTON_ROUNDS; r++) begin
			y2 = mul_c(y, y, 62);
			t = THREE_Q61 - mul_c(g, y2, 61);
			y = mul_c(y, t, 62);
		end
		return y >>> (62 - frac);
	endfunction

	localparam logic signed [63:0] DEG_K62 = pi4_q62() / 64'sd450000000;

	function automatic int cordic_lat(input int steps);
		return steps + MUL_LAT + 2;
	endfunction

	function automatic int ecef_lat(input int steps);
		return cordic_lat(steps) + 5 * MUL_LAT + 3 * MUL_LAT * NEWTON_ROUNDS;
	endfunction

endpackage

FILE: rtl/gte_mul.sv
// ----------------------------------------------------------------------------
// gte_mul: pipelined 64x64 signed multiply with floor shift
// Four 33x33 partial products, two partial sums, then the final sum and
// shift; three register stages.
// ----------------------------------------------------------------------------
module gte_mul #(
	parameter int SHIFT = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] p
);

	logic signed [32:0]  al, ah, bl, bh;
	logic signed [65:0]  p00_s1, p01_s1, p10_s1, p11_s1;
	logic signed [127:0] lo_s2, hi_s2, full;
	logic signed [63:0]  p_s3;

	assign al = $signed({1'b0, a[31:0]});
	assign ah = $signed({a[63], a[63:32]});
	assign bl = $signed({1'b0, b[31:0]});
	assign bh = $signed({b[63], b[63:32]});

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= al * bl;
			p01_s1 <= al * bh;
			p10_s1 <= ah * bl;
			p11_s1 <= ah * bh;
			lo_s2  <= 128'(p00_s1) + (128'(p01_s1) <<< 32);
			hi_s2  <= (128'(p10_s1) <<< 32) + (128'(p11_s1) <<< 64);
			p_s3   <= full[SHIFT +: 64];
		end
	end

	assign full = lo_s2 + hi_s2;
	assign p    = p_s3;

endmodule

FILE: rtl/gte_dly.sv
// ----------------------------------------------------------------------------
// gte_dly: enabled delay line
// Holds side data in step with the multiplier stages.
// ----------------------------------------------------------------------------
module gte_dly #(
	parameter int W     = 64,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

FILE: rtl/gte_cordic.sv
// ----------------------------------------------------------------------------
// gte_cordic: angle to sine and cosine
// Scales 1e-7 degree to radians, folds into +-pi/2, then runs one
// rotation step per stage.
// ----------------------------------------------------------------------------
module gte_cordic #(
	parameter int STEPS = gte_pkg::CORDIC_STEPS_DFLT,
	parameter int FRAC  = gte_pkg::FRACTION_BITS_DFLT
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] angle,
	output logic signed [63:0] sin_v,
	output logic signed [63:0] cos_v
);

	localparam logic signed [63:0] PI4     = gte_pkg::pi4_q62();
	localparam logic signed [63:0] HALF_PI = PI4 >>> (61 - FRAC);
	localparam logic signed [63:0] PI      = PI4 >>> (60 - FRAC);
	localparam logic signed [63:0] X0      = gte_pkg::cordic_x0(STEPS, FRAC);

	logic signed [63:0] z_rad;
	logic signed [63:0] x_s [STEPS+1];
	logic signed [63:0] y_s [STEPS+1];
	logic signed [63:0] z_s [STEPS+1];
	logic               flip_s [STEPS+1];
	logic signed [63:0] sin_s, cos_s;

	gte_mul #(.SHIFT(62 - FRAC)) u_rad (
		.clk (clk),
		.en  (en),
		.a   (64'(angle)),
		.b   (gte_pkg::DEG_K62),
		.p   (z_rad)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= X0;
			y_s[0] <= 64'sd0;
			priority if (z_rad > HALF_PI) begin
				z_s[0]    <= z_rad - PI;
				flip_s[0] <= 1'b1;
			end else if (z_rad < -HALF_PI) begin
				z_s[0]    <= z_rad + PI;
				flip_s[0] <= 1'b1;
			end else begin
				z_s[0]    <= z_rad;
				flip_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [63:0] AT = gte_pkg::atan_entry(i, FRAC);
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (z_s[i] >= 64'sd0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s <= flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
			cos_s <= flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		end
	end

	assign sin_v = sin_s;
	assign cos_v = cos_s;

endmodule

FILE: rtl/gte_rsqrt.sv
// ----------------------------------------------------------------------------
// gte_rsqrt: pipelined Newton reciprocal square root
// Q62 in and out, fixed number of rounds, three multiplies per round.
// ----------------------------------------------------------------------------
module gte_rsqrt (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] w,
	output logic signed [63:0] r
);

	localparam int R = gte_pkg::NEWTON_ROUNDS;
	localparam int M = gte_pkg::MUL_LAT;

	logic signed [63:0] y_r [R+1];
	logic signed [63:0] w_r [R+1];

	assign y_r[0] = gte_pkg::ONE_Q62;
	assign w_r[0] = w;

	for (genvar g = 0; g < R; g++) begin : g_round
		logic signed [63:0] y2, wd, q, t, yd;

		gte_mul #(.SHIFT(62)) u_sq (
			.clk (clk), .en (en), .a (y_r[g]), .b (y_r[g]), .p (y2)
		);
		gte_dly #(.W(64), .DEPTH(M)) u_wd (
			.clk (clk), .en (en), .d (w_r[g]), .q (wd)
		);
		gte_mul #(.SHIFT(63)) u_wy (
			.clk (clk), .en (en), .a (wd), .b (y2), .p (q)
		);
		assign t = gte_pkg::THREE_Q61 - q;
		gte_dly #(.W(64), .DEPTH(2 * M)) u_yd (
			.clk (clk), .en (en), .d (y_r[g]), .q (yd)
		);
		gte_mul #(.SHIFT(62)) u_upd (
			.clk (clk), .en (en), .a (yd), .b (t), .p (y_r[g+1])
		);
		if (g < R - 1) begin : g_wfwd
			gte_dly #(.W(64), .DEPTH(2 * M)) u_wn (
				.clk (clk), .en (en), .d (wd), .q (w_r[g+1])
			);
		end else begin : g_wlast
			assign w_r[g+1] = wd;
		end
	end

	assign r = y_r[R];

endmodule

FILE: rtl/gte_ecef.sv
// ----------------------------------------------------------------------------
// gte_ecef: geodetic fix to Earth-centred coordinates
// Trig by CORDIC, prime-vertical radius by Newton, then the scaled
// products; coordinates in mm with 16 fractional bits.
// ----------------------------------------------------------------------------
module gte_ecef #(
	parameter int STEPS = gte_pkg::CORDIC_STEPS_DFLT,
	parameter int FRAC  = gte_pkg::FRACTION_BITS_DFLT
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [gte_pkg::LAT_W-1:0]   lat,
	input  logic signed [gte_pkg::LON_W-1:0]   lon,
	input  logic signed [gte_pkg::HGT_W-1:0]   hgt,
	output logic signed [63:0]                 px,
	output logic signed [63:0]                 py,
	output logic signed [63:0]                 pz,
	output gte_pkg::trig_t                     trig
);

	localparam int M    = gte_pkg::MUL_LAT;
	localparam int T    = gte_pkg::cordic_lat(STEPS);
	localparam int L_V  = 3 * M + 3 * M * gte_pkg::NEWTON_ROUNDS;
	localparam int L_M1 = L_V + M;

	logic signed [63:0] sp, cp, sl, cl;
	logic signed [63:0] ms, sa, s2, e2s, w, r, v;
	logic signed [63:0] cp_d, sp_d, sl_d, cl_d;
	logic signed [63:0] hq, hq_v, hq_k, vh, m1, k, kz;

	gte_cordic #(.STEPS(STEPS), .FRAC(FRAC)) u_lat (
		.clk (clk), .en (en), .angle (32'(lat)), .sin_v (sp), .cos_v (cp)
	);
	gte_cordic #(.STEPS(STEPS), .FRAC(FRAC)) u_lon (
		.clk (clk), .en (en), .angle (lon), .sin_v (sl), .cos_v (cl)
	);

	assign ms = (sp < 64'sd0) ? -sp : sp;
	assign sa = ms <<< (62 - FRAC);

	gte_mul #(.SHIFT(62)) u_s2 (
		.clk (clk), .en (en), .a (sa), .b (sa), .p (s2)
	);
	gte_mul #(.SHIFT(62)) u_e2s (
		.clk (clk), .en (en), .a (gte_pkg::E2_Q62), .b (s2), .p (e2s)
	);
	assign w = gte_pkg::ONE_Q62 - e2s;

	gte_rsqrt u_rsqrt (
		.clk (clk), .en (en), .w (w), .r (r)
	);
	gte_mul #(.SHIFT(46)) u_v (
		.clk (clk), .en (en), .a (gte_pkg::RE_MM), .b (r), .p (v)
	);

	gte_dly #(.W(64), .DEPTH(L_V)) u_cpd (
		.clk (clk), .en (en), .d (cp), .q (cp_d)
	);
	gte_dly #(.W(64), .DEPTH(L_M1)) u_spd (
		.clk (clk), .en (en), .d (sp), .q (sp_d)
	);
	gte_dly #(.W(64), .DEPTH(L_M1)) u_sld (
		.clk (clk), .en (en), .d (sl), .q (sl_d)
	);
	gte_dly #(.W(64), .DEPTH(L_M1)) u_cld (
		.clk (clk), .en (en), .d (cl), .q (cl_d)
	);

	assign hq = 64'(hgt) <<< 16;
	gte_dly #(.W(64), .DEPTH(T + L_V)) u_hqv (
		.clk (clk), .en (en), .d (hq), .q (hq_v)
	);
	gte_dly #(.W(64), .DEPTH(M)) u_hqk (
		.clk (clk), .en (en), .d (hq_v), .q (hq_k)
	);

	assign vh = v + hq_v;
	gte_mul #(.SHIFT(FRAC)) u_m1 (
		.clk (clk), .en (en), .a (vh), .b (cp_d), .p (m1)
	);
	gte_mul #(.SHIFT(FRAC)) u_px (
		.clk (clk), .en (en), .a (m1), .b (cl_d), .p (px)
	);
	gte_mul #(.SHIFT(FRAC)) u_py (
		.clk (clk), .en (en), .a (m1), .b (sl_d), .p (py)
	);

	gte_mul #(.SHIFT(62)) u_k (
		.clk (clk), .en (en), .a (v), .b (gte_pkg::ONE_MINUS_E2), .p (k)
	);
	assign kz = k + hq_k;
	gte_mul #(.SHIFT(FRAC)) u_pz (
		.clk (clk), .en (en), .a (kz), .b (sp_d), .p (pz)
	);

	assign trig.sp = sp;
	assign trig.cp = cp;
	assign trig.sl = sl;
	assign trig.cl = cl;

endmodule

FILE: rtl/geodetic_to_local_enu_unit.sv
// ----------------------------------------------------------------------------
// geodetic_to_local_enu_unit: geodetic fix to local east-north-up offset
// WGS84 fixed-point pipeline from latitude, longitude and height to
// saturated ENU offsets in millimetres relative to a configured origin.
// ----------------------------------------------------------------------------
// Usage:
//   fix channel (fix_valid/fix_ready) carries one geodetic word per cycle.
//   enu channel (enu_valid/enu_ready) returns one offset word per fix, in order.
//   cfg channel writes the origin: index 0 latitude, 1 longitude, 2 height;
//   other indexes are ignored. cfg_ready is always high. Write the origin
//   while no fix is in flight; a fix accepted in the cycle after the write
//   already sees the new origin.
// Pipeline: its depth is set by the CORDIC stages, six Newton rounds of
//   three multiplies each and the three-stage 64x64 multipliers.
// Throughput: one word per cycle while enu_ready is high.
// Stall: when the output word waits, the fix pipeline holds and fix_ready
//   drops while the origin path runs on; nothing is lost or repeated.
// Reset: arst_n clears valid bits and origin registers (origin at zero).
// ----------------------------------------------------------------------------
module geodetic_to_local_enu_unit #(
	parameter int CORDIC_STEPS  = gte_pkg::CORDIC_STEPS_DFLT,
	parameter int FRACTION_BITS = gte_pkg::FRACTION_BITS_DFLT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fix_valid,
	output logic                                fix_ready,
	input  logic signed [gte_pkg::LAT_W-1:0]    fix_latitude,
	input  logic signed [gte_pkg::LON_W-1:0]    fix_longitude,
	input  logic signed [gte_pkg::HGT_W-1:0]    fix_height_mm,
	output logic                                enu_valid,
	input  logic                                enu_ready,
	output logic signed [gte_pkg::OUT_W-1:0]    east_mm,
	output logic signed [gte_pkg::OUT_W-1:0]    north_mm,
	output logic signed [gte_pkg::OUT_W-1:0]    up_mm,
	output logic                                clipped,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gte_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gte_pkg::CFG_DAT_W-1:0]       cfg_data
);

	localparam int M   = gte_pkg::MUL_LAT;
	localparam int LAT = gte_pkg::ecef_lat(CORDIC_STEPS) + M + 2;

	logic                             en;
	logic [LAT-1:0]                   vld_q;
	logic signed [gte_pkg::LAT_W-1:0] org_lat_q;
	logic signed [gte_pkg::LON_W-1:0] org_lon_q;
	logic signed [gte_pkg::HGT_W-1:0] org_hgt_q;

	logic signed [63:0] ox, oy, oz, cx, cy, cz;
	gte_pkg::trig_t     ot, ct;
	logic signed [63:0] spcl, spsl, cpcl, cpsl;
	logic signed [63:0] dx_s1, dy_s1, dz_s1;
	logic signed [63:0] rc [8];
	logic signed [63:0] rd [8];
	logic signed [63:0] rp [8];
	logic signed [63:0] ax_sum [3];
	logic signed [63:0] ax_rnd [3];
	logic [2:0]         ax_clip;
	logic signed [63:0] ax_val [3];
	logic signed [gte_pkg::OUT_W-1:0] east_s, north_s, up_s;
	logic               clip_s;

	assign en        = !vld_q[LAT-1] || enu_ready;
	assign fix_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], fix_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_lat_q <= '0;
			org_lon_q <= '0;
			org_hgt_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gte_pkg::REG_ORIGIN_LAT: org_lat_q <= cfg_data[gte_pkg::LAT_W-1:0];
				gte_pkg::REG_ORIGIN_LON: org_lon_q <= cfg_data[gte_pkg::LON_W-1:0];
				gte_pkg::REG_ORIGIN_HGT: org_hgt_q <= cfg_data[gte_pkg::HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// origin path runs free
	gte_ecef #(.STEPS(CORDIC_STEPS), .FRAC(FRACTION_BITS)) u_org (
		.clk (clk), .en (1'b1), .lat (org_lat_q), .lon (org_lon_q),
		.hgt (org_hgt_q), .px (ox), .py (oy), .pz (oz), .trig (ot)
	);
	gte_ecef #(.STEPS(CORDIC_STEPS), .FRAC(FRACTION_BITS)) u_fix (
		.clk (clk), .en (en), .lat (fix_latitude), .lon (fix_longitude),
		.hgt (fix_height_mm), .px (cx), .py (cy), .pz (cz), .trig (ct)
	);

	gte_mul #(.SHIFT(FRACTION_BITS)) u_spcl (
		.clk (clk), .en (1'b1), .a (ot.sp), .b (ot.cl), .p (spcl)
	);
	gte_mul #(.SHIFT(FRACTION_BITS)) u_spsl (
		.clk (clk), .en (1'b1), .a (ot.sp), .b (ot.sl), .p (spsl)
	);
	gte_mul #(.SHIFT(FRACTION_BITS)) u_cpcl (
		.clk (clk), .en (1'b1), .a (ot.cp), .b (ot.cl), .p (cpcl)
	);
	gte_mul #(.SHIFT(FRACTION_BITS)) u_cpsl (
		.clk (clk), .en (1'b1), .a (ot.cp), .b (ot.sl), .p (cpsl)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= cx - ox;
			dy_s1 <= cy - oy;
			dz_s1 <= cz - oz;
		end
	end

	assign rc[0] = -ot.sl;  assign rd[0] = dx_s1;
	assign rc[1] = ot.cl;   assign rd[1] = dy_s1;
	assign rc[2] = -spcl;   assign rd[2] = dx_s1;
	assign rc[3] = -spsl;   assign rd[3] = dy_s1;
	assign rc[4] = ot.cp;   assign rd[4] = dz_s1;
	assign rc[5] = cpcl;    assign rd[5] = dx_s1;
	assign rc[6] = cpsl;    assign rd[6] = dy_s1;
	assign rc[7] = ot.sp;   assign rd[7] = dz_s1;

	for (genvar i = 0; i < 8; i++) begin : g_rot
		gte_mul #(.SHIFT(FRACTION_BITS)) u_rot (
			.clk (clk), .en (en), .a (rc[i]), .b (rd[i]), .p (rp[i])
		);
	end

	assign ax_sum[0] = rp[0] + rp[1];
	assign ax_sum[1] = rp[2] + rp[3] + rp[4];
	assign ax_sum[2] = rp[5] + rp[6] + rp[7];

	for (genvar j = 0; j < 3; j++) begin : g_fin
		assign ax_rnd[j] = (ax_sum[j] + gte_pkg::HALF_MM_Q16) >>> 16;
		always_comb begin
			priority if (ax_rnd[j] > gte_pkg::LIMIT_MM) begin
				ax_val[j]  = gte_pkg::LIMIT_MM;
				ax_clip[j] = 1'b1;
			end else if (ax_rnd[j] < -gte_pkg::LIMIT_MM) begin
				ax_val[j]  = -gte_pkg::LIMIT_MM;
				ax_clip[j] = 1'b1;
			end else begin
				ax_val[j]  = ax_rnd[j];
				ax_clip[j] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			east_s  <= ax_val[0][gte_pkg::OUT_W-1:0];
			north_s <= ax_val[1][gte_pkg::OUT_W-1:0];
			up_s    <= ax_val[2][gte_pkg::OUT_W-1:0];
			clip_s  <= |ax_clip;
		end
	end

	assign enu_valid = vld_q[LAT-1];
	assign east_mm   = east_s;
	assign north_mm  = north_s;
	assign up_mm     = up_s;
	assign clipped   = clip_s;

`ifndef SYNTHESIS
	localparam logic signed [gte_pkg::OUT_W-1:0] LIM = gte_pkg::LIMIT_MM[gte_pkg::OUT_W-1:0];

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		enu_valid && clipped |-> east_mm == LIM || east_mm == -LIM ||
			north_mm == LIM || north_mm == -LIM || up_mm == LIM || up_mm == -LIM)
		else $error("clipped set with no offset at the limit");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		enu_valid |-> east_mm <= LIM && east_mm >= -LIM && north_mm <= LIM &&
			north_mm >= -LIM && up_mm <= LIM && up_mm >= -LIM)
		else $error("offset beyond saturation limit");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
`endif

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: geodetic to local ENU converter
// Drives geodetic fixes over valid/ready with random idling and a long
// output hold-off, writes several origin settings between phases, and checks
// every offset word against a fixed-point WGS84 predictor or typed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int STEPS = gte_pkg::CORDIC_STEPS_DFLT;
	localparam int FB    = gte_pkg::FRACTION_BITS_DFLT;
	localparam int IDX_W = gte_pkg::CFG_IDX_W;
	localparam int DAT_W = gte_pkg::CFG_DAT_W;
	localparam int LAT_W = gte_pkg::LAT_W;
	localparam int LON_W = gte_pkg::LON_W;
	localparam int HGT_W = gte_pkg::HGT_W;
	localparam int OUT_W = gte_pkg::OUT_W;

	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int MAX_SHOWN  = 10;
	localparam int STALL_CAP  = 20000;
	localparam int HOLD_LEN   = 600;
	localparam int PHASE_LEN  = 300;

	typedef struct packed {
		logic signed [OUT_W-1:0] east;
		logic signed [OUT_W-1:0] north;
		logic signed [OUT_W-1:0] up;
		logic                    clip;
	} enu_t;

	typedef struct {
		bit   typed;
		enu_t want;
	} note_t;

	typedef struct {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
		logic signed [HGT_W-1:0] hgt;
		bit                      typed;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic fix_valid = 1'b0;
	logic fix_ready;
	logic signed [LAT_W-1:0] fix_latitude = '0;
	logic signed [LON_W-1:0] fix_longitude = '0;
	logic signed [HGT_W-1:0] fix_height_mm = '0;
	logic enu_valid;
	logic enu_ready = 1'b0;
	logic signed [OUT_W-1:0] east_mm, north_mm, up_mm;
	logic clipped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DAT_W-1:0] cfg_data = '0;

	geodetic_to_local_enu_unit dut (.*);

	always #10 clk = ~clk;

	logic signed [63:0] pi4, degk, gain_x0;
	logic signed [63:0] arctan [STEPS];
	logic signed [63:0] org_lat, org_lon, org_hgt;

	note_t notes [$];
	enu_t  owed [$];
	int    errors = 0;
	bit    calm = 1'b0;
	bit    hold_req = 1'b0;

	function automatic logic signed [63:0] mulf(input logic signed [63:0] a,
			input logic signed [63:0] b, input int s);
		logic signed [127:0] p;
		p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
		p = p >>> s;
		return p[63:0];
	endfunction

	function automatic logic signed [63:0] arccot(input logic signed [63:0] q);
		logic signed [63:0] t, q2, sum, term;
		int k;
		t = gte_pkg::ONE_Q62 / q;
		q2 = q * q;
		sum = 0;
		k = 0;
		while (t != 0) begin
			term = t / (2 * k + 1);
			sum = (k % 2) ? sum - term : sum + term;
			t = t / q2;
			k++;
		end
		return sum;
	endfunction

	function automatic logic signed [63:0] rsqrt(input logic signed [63:0] p,
			input int pf, input logic signed [63:0] y);
		logic signed [63:0] y2, t;
		for (int r = 0; r < gte_pkg::NEWTON_ROUNDS; r++) begin
			y2 = mulf(y, y, 62);
			t = gte_pkg::THREE_Q61 - mulf(p, y2, pf + 1);
			y = mulf(y, t, 62);
		end
		return y;
	endfunction

	task automatic build_tables();
		logic signed [63:0] g, sum, term;
		int e, k;
		g = 64'sd1 <<< 60;
		pi4 = 4 * arccot(5) - arccot(239);
		for (int i = 0; i < STEPS; i++) begin
			sum = 0;
			if (i == 0) begin
				sum = pi4;
			end else begin
				k = 0;
				e = 62 - i;
				while (e >= 0) begin
					term = (64'sd1 <<< e) / (2 * k + 1);
					sum = (k % 2) ? sum - term : sum + term;
					k++;
					e = 62 - i * (2 * k + 1);
				end
			end
			arctan[i] = sum >>> (62 - FB);
			if (2 * i < 64) g = g + (g >>> (2 * i));
		end
		gain_x0 = rsqrt(g, 60, (gte_pkg::ONE_Q62 / 10) * 6) >>> (62 - FB);
		degk = pi4 / 64'sd450000000;
	endtask

	task automatic rotate(input logic signed [63:0] a,
			output logic signed [63:0] s, output logic signed [63:0] c);
		logic signed [63:0] z, hp, pi, x, y, xs, ys;
		bit flip;
		z = mulf(a, degk, 62 - FB);
		hp = pi4 >>> (61 - FB);
		pi = pi4 >>> (60 - FB);
		x = gain_x0;
		y = 0;
		flip = 0;
		if (z > hp) begin
			z = z - pi;
			flip = 1;
		end else if (z < -hp) begin
			z = z + pi;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	task automatic earth_xyz(input logic signed [63:0] lat, lon, h,
			output logic signed [63:0] px, py, pz,
			output logic signed [63:0] sp, cp, sl, cl);
		logic signed [63:0] sa, s2, w, r, v, hq, vh, vc;
		rotate(lat, sp, cp);
		rotate(lon, sl, cl);
		sa = (sp < 0 ? -sp : sp) <<< (62 - FB);
		s2 = mulf(sa, sa, 62);
		w = gte_pkg::ONE_Q62 - mulf(gte_pkg::E2_Q62, s2, 62);
		r = rsqrt(w, 62, gte_pkg::ONE_Q62);
		v = mulf(gte_pkg::RE_MM, r, 46);
		hq = h * 65536;
		vh = v + hq;
		vc = mulf(vh, cp, FB);
		px = mulf(vc, cl, FB);
		py = mulf(vc, sl, FB);
		pz = mulf(mulf(v, gte_pkg::ONE_MINUS_E2, 62) + hq, sp, FB);
	endtask

	function automatic logic signed [63:0] to_mm(input logic signed [63:0] q16,
			inout logic clip);
		logic signed [63:0] mm;
		mm = (q16 + gte_pkg::HALF_MM_Q16) >>> 16;
		if (mm > gte_pkg::LIMIT_MM) begin
			clip = 1;
			return gte_pkg::LIMIT_MM;
		end
		if (mm < -gte_pkg::LIMIT_MM) begin
			clip = 1;
			return -gte_pkg::LIMIT_MM;
		end
		return mm;
	endfunction

	task automatic predict_enu(input logic signed [63:0] lat, lon, h, output enu_t r);
		localparam int F = FB;
		logic signed [63:0] ox, oy, oz, cx, cy, cz, sp, cp, sl, cl, t0, t1, t2, t3;
		logic signed [63:0] dx, dy, dz, e, n, u;
		logic clip;
		earth_xyz(org_lat, org_lon, org_hgt, ox, oy, oz, sp, cp, sl, cl);
		earth_xyz(lat, lon, h, cx, cy, cz, t0, t1, t2, t3);
		dx = cx - ox;
		dy = cy - oy;
		dz = cz - oz;
		e = mulf(-sl, dx, F) + mulf(cl, dy, F);
		n = mulf(-mulf(sp, cl, F), dx, F) + mulf(-mulf(sp, sl, F), dy, F)
			+ mulf(cp, dz, F);
		u = mulf(mulf(cp, cl, F), dx, F) + mulf(mulf(cp, sl, F), dy, F)
			+ mulf(sp, dz, F);
		clip = 0;
		r.east = to_mm(e, clip);
		r.north = to_mm(n, clip);
		r.up = to_mm(u, clip);
		r.clip = clip;
	endtask

	always @(posedge clk) begin
		enu_t w, got;
		note_t nt;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gte_pkg::REG_ORIGIN_LAT: org_lat = $signed(cfg_data[LAT_W-1:0]);
				gte_pkg::REG_ORIGIN_LON: org_lon = $signed(cfg_data[LON_W-1:0]);
				gte_pkg::REG_ORIGIN_HGT: org_hgt = $signed(cfg_data[HGT_W-1:0]);
				default: ;
			endcase
		end
		if (fix_valid && fix_ready) begin
			nt = notes.pop_front();
			if (nt.typed) w = nt.want;
			else predict_enu(fix_latitude, fix_longitude, fix_height_mm, w);
			owed.push_back(w);
		end
		if (enu_valid && enu_ready) begin
			got.east = east_mm;
			got.north = north_mm;
			got.up = up_mm;
			got.clip = clipped;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN) $display("unexpected word: %0d %0d %0d %0b",
					got.east, got.north, got.up, got.clip);
			end else begin
				w = owed.pop_front();
				if (got != w) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
							w.east, w.north, w.up, w.clip,
							got.east, got.north, got.up, got.clip);
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				enu_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 0;
			end else begin
				enu_ready <= calm || ($urandom_range(99) >= 31);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((fix_valid && fix_ready) || (enu_valid && enu_ready) ||
					(cfg_valid && cfg_ready)) quiet = 0;
			else quiet++;
			if (quiet >= STALL_CAP) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	task automatic send_fix(input logic signed [LAT_W-1:0] lat,
			input logic signed [LON_W-1:0] lon, input logic signed [HGT_W-1:0] h,
			input bit typed);
		note_t nt;
		nt.typed = typed;
		nt.want = '{east: '0, north: '0, up: '0, clip: 1'b0};
		while (!calm && $urandom_range(99) < 31) begin
			fix_valid <= 1'b0;
			@(posedge clk);
		end
		notes.push_back(nt);
		fix_valid <= 1'b1;
		fix_latitude <= lat;
		fix_longitude <= lon;
		fix_height_mm <= h;
		do @(posedge clk); while (!fix_ready);
	endtask

	task automatic drain();
		fix_valid <= 1'b0;
		@(posedge clk);
		while (owed.size() != 0 || notes.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx,
			input logic [DAT_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_origin(input logic [DAT_W-1:0] lat, lon, h);
		write_reg(gte_pkg::REG_ORIGIN_LAT, lat);
		write_reg(gte_pkg::REG_ORIGIN_LON, lon);
		write_reg(gte_pkg::REG_ORIGIN_HGT, h);
		write_reg(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_fix();
		int pick;
		logic signed [63:0] lat, lon, h;
		pick = $urandom_range(99);
		if (pick < 55) begin
			lat = $signed($urandom_range(1800000000)) - 900000000;
			lon = $signed({1'b0, $urandom}) % 64'sd3600000001 - 1800000000;
			h = $signed($urandom_range(110000000)) - 10000000;
		end else if (pick < 80) begin
			lat = org_lat + $signed($urandom_range(200000)) - 100000;
			lon = org_lon + $signed($urandom_range(200000)) - 100000;
			h = org_hgt + $signed($urandom_range(200000)) - 100000;
		end else if (pick < 88) begin
			lat = $urandom_range(1) ? 900000000 : -900000000;
			lon = $signed($urandom);
			h = $signed($urandom_range(10000)) - 5000;
		end else begin
			lat = $signed($urandom);
			lon = $signed($urandom);
			h = $signed($urandom);
		end
		send_fix(lat[LAT_W-1:0], lon[LON_W-1:0], h[HGT_W-1:0], 1'b0);
	endtask

	row_t rows [] = '{
		'{31'sd0, 32'sd0, 28'sd0, 1'b1},
		'{31'sd900000000, 32'sd0, 28'sd0, 1'b0},
		'{-31'sd900000000, 32'sd0, 28'sd0, 1'b0},
		'{31'sd0, 32'sd1800000000, 28'sd0, 1'b0},
		'{31'sd0, -32'sd1800000000, 28'sd0, 1'b0},
		'{31'sd0, 32'sd900000000, 28'sd100000000, 1'b0},
		'{31'sd0, -32'sd900000000, -28'sd10000000, 1'b0},
		'{31'sd1073741823, 32'sd0, 28'sd0, 1'b0},
		'{-31'sd1073741824, 32'sd0, 28'sd0, 1'b0},
		'{31'sd0, 32'sd2147483647, 28'sd0, 1'b0},
		'{31'sd0, -32'sd2147483648, 28'sd0, 1'b0},
		'{31'sd0, 32'sd0, 28'sd134217727, 1'b0},
		'{31'sd0, 32'sd0, -28'sd134217728, 1'b0},
		'{31'sd1073741823, 32'sd2147483647, 28'sd134217727, 1'b0},
		'{-31'sd1073741824, -32'sd2147483648, -28'sd134217728, 1'b0},
		'{31'sd450000000, 32'sd1000000000, 28'sd5000, 1'b0},
		'{31'sd1, -32'sd1, 28'sd1, 1'b0}
	};

	initial begin
		build_tables();
		org_lat = 0;
		org_lon = 0;
		org_hgt = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_fix(rows[i].lat, rows[i].lon, rows[i].hgt, rows[i].typed);
		drain();
		set_origin(32'h4000_0000, 32'h7fff_ffff, 32'h0800_0000);
		send_fix(-31'sd1073741824, 32'sd2147483647, -28'sd134217728, 1'b1);
		send_fix(31'sd0, 32'sd0, 28'sd0, 1'b0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_origin(32'd900000000, 32'd1800000000, 32'd100000000);
				1: set_origin(-32'sd900000000, -32'sd1800000000, -32'sd10000000);
				2: set_origin(32'h3fff_ffff, 32'h8000_0000, 32'h07ff_ffff);
				default: set_origin($urandom_range(1800000000) - 900000000,
					$urandom, $urandom_range(110000000) - 10000000);
			endcase
			calm = (ph == 3);
			if (ph == 1) hold_req = 1;
			repeat (PHASE_LEN) random_fix();
			drain();
		end
		calm = 0;
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/gte_pkg.sv
rtl/gte_mul.sv
rtl/gte_dly.sv
rtl/gte_cordic.sv
rtl/gte_rsqrt.sv
rtl/gte_ecef.sv
rtl/geodetic_to_local_enu_unit.sv
sim/testbench.sv
